// ===== rtl/core/trimmed_mean_deadband_smoother_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trimmed-mean deadband smoother
// Shared property forms; each expects clk and rst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_DEADBAND_SMOOTHER_CORE_ASSERT_SVH
`define TRIMMED_MEAN_DEADBAND_SMOOTHER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMDS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tmds_pkg.sv =====
// ----------------------------------------------------------------------------
// tmds_pkg
// Types and fixed constants of the trimmed-mean deadband smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package tmds_pkg;

    localparam int DATA_W      = 8;
    localparam int CELL_W      = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_W       = 8;

    // x / 10 for x <= 2550 equals (x * 6554) >> 16.
    localparam int BLEND_W     = 12;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] BLEND_RECIP = 13'd6554;
    localparam int BLEND_SHIFT = 16;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_DEADBAND = 2'd0;
    localparam cfg_idx_t CFG_BYPASS   = 2'd1;
    localparam cfg_idx_t CFG_FLOOR    = 2'd2;

    typedef struct packed {
        logic [CELL_W-1:0] cell_out;
        logic [DATA_W-1:0] filtered;
    } tmds_result_t;

    typedef struct packed {
        logic         valid;
        tmds_result_t data;
    } oq_push_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmds_out_fifo.sv =====
// ----------------------------------------------------------------------------
// tmds_out_fifo
// Small result queue that decouples the update pipeline from the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tmds_out_fifo
    import tmds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  oq_push_t           push,
    output logic               out_valid,
    input  logic               out_ready,
    output tmds_result_t       out_data,
    output logic [OQ_AW:0]     count
);

    tmds_result_t         entry_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]     wr_ptr_reg;
    logic [OQ_AW-1:0]     wr_ptr_next;
    logic [OQ_AW-1:0]     rd_ptr_reg;
    logic [OQ_AW-1:0]     rd_ptr_next;
    logic [OQ_AW:0]       count_reg;
    logic [OQ_AW:0]       count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (OQ_AW+1)'(push.valid) - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/trimmed_mean_deadband_smoother_core.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean deadband smoother core
// Per-cell history ring, trimmed mean and deadband blend for a sensor matrix.
//
// Input transactions on s_axis carry one cell sample; frame_start on tuser
// advances the history slot before the sample is stored. Each input
// transaction yields exactly one output transaction on m_axis, in order.
// Path: the sample and the cell memory read are registered into stage 1, the
// merged history and trimmed sum into stage 2, and the result into the queue.
// Throughput: one transaction per clock while s_axis_tready is high, kept up by
// the read-modify-write loop over the cell memory (read, update, write back),
// which forwards in-flight updates of the same cell.
// Reset: after rst_n is released the cell memory is cleared, one cell per
// cycle, for CELLS cycles; s_axis_tready stays low during that pass.
// Configuration writes are taken at any time, including during clearing.
// Stall: a four-entry result queue absorbs items still in the pipeline;
// s_axis_tready otherwise drops only when queued plus in-flight items would exceed it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trimmed_mean_deadband_smoother_core_assert.svh"

module trimmed_mean_deadband_smoother_core
    import tmds_pkg::*;
#(
    parameter int HISTORY = 4,
    parameter int CELLS   = 2048
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] sample, [18:8] cell_index
    input  logic                   s_axis_tuser,   // [0] frame_start
    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] filtered, [18:8] cell_out
    // Configuration write port.
    input  logic                   cfg_we,
    input  cfg_idx_t               cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    // Address width of the cell memory and width of the history slot.
    localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SLOT_W   = $clog2(HISTORY);
    localparam int HIST_W   = HISTORY * DATA_W;
    localparam int MEM_W    = HIST_W + DATA_W;
    localparam int SUM_W    = $clog2(HISTORY * 255 + 1);
    localparam int CELL_XW  = 13;
    localparam int TRIM_CNT = HISTORY - 2;
    localparam int TRIM_SHIFT = (TRIM_CNT >= 8) ? 3 :
                                (TRIM_CNT >= 4) ? 2 :
                                (TRIM_CNT >= 2) ? 1 : 0;
    localparam int PROD_W   = BLEND_W + RECIP_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] deadband_reg;
    logic [DATA_W-1:0] bypass_reg;
    logic [DATA_W-1:0] floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= 8'd1;
            bypass_reg   <= 8'd2;
            floor_reg    <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DEADBAND: deadband_reg <= cfg_wdata;
                CFG_BYPASS:   bypass_reg   <= cfg_wdata;
                CFG_FLOOR:    floor_reg    <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Intake: slot pointer, range check and memory read.
    // ------------------------------------------------------------------
    logic                 accept;
    logic [DATA_W-1:0]    in_sample;
    logic [CELL_W-1:0]    in_cell;
    logic [CELL_XW-1:0]   in_cell_wide;
    logic                 in_range;
    logic [AW-1:0]        in_addr;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic                 clr_busy_reg;
    logic                 clr_busy_next;
    logic [AW-1:0]        clr_cnt_reg;
    logic [AW-1:0]        clr_cnt_next;
    logic                 clr_last;
    logic [OQ_AW:0]       oq_count;
    logic [OQ_AW+1:0]     occupancy;

    logic                 s1_valid_reg;
    logic                 s2_valid_reg;

    assign in_sample    = s_axis_tdata[DATA_W-1:0];
    assign in_cell      = s_axis_tdata[DATA_W +: CELL_W];
    assign in_cell_wide = CELL_XW'(in_cell);
    assign in_range     = (in_cell_wide < CELL_XW'(CELLS));
    assign in_addr      = in_cell_wide[AW-1:0];

    // Items in the queue plus items still in the update pipeline.
    assign occupancy = (OQ_AW+2)'(oq_count) + (OQ_AW+2)'(s1_valid_reg)
                     + (OQ_AW+2)'(s2_valid_reg);

    assign s_axis_tready = !clr_busy_reg && (occupancy < (OQ_AW+2)'(OQ_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        slot_next = slot_reg;
        if (accept && s_axis_tuser)
        begin
            slot_next = (slot_reg == SLOT_W'(HISTORY - 1)) ? '0 : slot_reg + 1'b1;
        end
    end

    // Clearing pass over the cell memory after reset.
    assign clr_last = (clr_cnt_reg == AW'(CELLS - 1));

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_last)
            begin
                clr_busy_next = 1'b0;
                clr_cnt_next  = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Cell memory: one word per cell, history bytes below, output above.
    // ------------------------------------------------------------------
    logic [MEM_W-1:0] cell_mem [CELLS];
    logic [MEM_W-1:0] mem_q_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [MEM_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            mem_q_reg <= cell_mem[in_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: merge the new sample, reduce the history.
    // ------------------------------------------------------------------
    logic                 s1_valid_next;
    logic                 s1_inrange_reg;
    logic [CELL_W-1:0]    s1_cell_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic [DATA_W-1:0]    s1_sample_reg;
    logic [SLOT_W-1:0]    s1_slot_reg;

    logic                 s2_valid_next;
    logic                 s2_inrange_reg;
    logic [CELL_W-1:0]    s2_cell_reg;
    logic [AW-1:0]        s2_addr_reg;
    logic [HIST_W-1:0]    s2_hist_reg;
    logic [SUM_W-1:0]     s2_tsum_reg;
    logic [DATA_W-1:0]    s2_prev_reg;

    logic                 lw_valid_reg;
    logic                 lw_valid_next;
    logic [AW-1:0]        lw_addr_reg;
    logic [HIST_W-1:0]    lw_hist_reg;
    logic [DATA_W-1:0]    lw_result_reg;

    logic                 fwd_s2;
    logic                 fwd_lw;
    logic [HIST_W-1:0]    base_hist;
    logic [DATA_W-1:0]    s1_prev;
    logic [HIST_W-1:0]    new_hist;
    logic [SUM_W-1:0]     sum_acc;
    logic [DATA_W-1:0]    hi_acc;
    logic [DATA_W-1:0]    lo_acc;
    logic [SUM_W-1:0]     trim_sum;

    assign s1_valid_next = accept;

    // The item one stage ahead has not reached memory yet; the one written
    // on the last edge was missed by a read-first access on that edge.
    assign fwd_s2 = s2_valid_reg && s2_inrange_reg && (s2_addr_reg == s1_addr_reg);
    assign fwd_lw = lw_valid_reg && (lw_addr_reg == s1_addr_reg);

    always_comb
    begin
        if (fwd_s2)
        begin
            base_hist = s2_hist_reg;
        end
        else if (fwd_lw)
        begin
            base_hist = lw_hist_reg;
        end
        else
        begin
            base_hist = mem_q_reg[HIST_W-1:0];
        end
        s1_prev = fwd_lw ? lw_result_reg : mem_q_reg[MEM_W-1 -: DATA_W];
    end

    always_comb
    begin
        sum_acc = '0;
        hi_acc  = '0;
        lo_acc  = '1;
        for (int i = 0; i < HISTORY; i++)
        begin
            new_hist[i*DATA_W +: DATA_W] = (s1_slot_reg == SLOT_W'(i)) ?
                                           s1_sample_reg : base_hist[i*DATA_W +: DATA_W];
            sum_acc = sum_acc + SUM_W'(new_hist[i*DATA_W +: DATA_W]);
            if (new_hist[i*DATA_W +: DATA_W] > hi_acc)
            begin
                hi_acc = new_hist[i*DATA_W +: DATA_W];
            end
            if (new_hist[i*DATA_W +: DATA_W] < lo_acc)
            begin
                lo_acc = new_hist[i*DATA_W +: DATA_W];
            end
        end
        trim_sum = sum_acc - SUM_W'(hi_acc) - SUM_W'(lo_acc);
    end

    // ------------------------------------------------------------------
    // Stage 2: mean, bypass, deadband blend, floor and write-back.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]    prev_eff;
    logic [SUM_W-1:0]     shifted;
    logic [DATA_W-1:0]    mean;
    logic [DATA_W-1:0]    diff;
    logic [BLEND_W-1:0]   blend_sum;
    logic [PROD_W-1:0]    blend_prod;
    logic [DATA_W-1:0]    blend_q;
    logic [DATA_W-1:0]    pick;
    logic [DATA_W-1:0]    result;
    logic                 s2_write;
    oq_push_t             oq_push;
    tmds_result_t         oq_head;

    // An update of the same cell written on the last edge supersedes the
    // previous output captured in stage 1.
    assign prev_eff = (lw_valid_reg && (lw_addr_reg == s2_addr_reg)) ?
                      lw_result_reg : s2_prev_reg;

    always_comb
    begin
        shifted = s2_tsum_reg >> TRIM_SHIFT;
        mean    = (shifted > SUM_W'(255)) ? '1 : shifted[DATA_W-1:0];
        diff    = (mean > prev_eff) ? mean - prev_eff : prev_eff - mean;

        // 3*mean + 7*prev, then divide by ten through the reciprocal.
        blend_sum  = BLEND_W'(mean) + BLEND_W'({mean, 1'b0})
                   + BLEND_W'({prev_eff, 3'b000}) - BLEND_W'(prev_eff);
        blend_prod = PROD_W'(blend_sum) * PROD_W'(BLEND_RECIP);
        blend_q    = blend_prod[BLEND_SHIFT +: DATA_W];

        priority if (mean < bypass_reg)
        begin
            pick = mean;
        end
        else if (diff > deadband_reg)
        begin
            pick = blend_q;
        end
        else
        begin
            pick = prev_eff;
        end

        result = (pick <= floor_reg) ? '0 : pick;
    end

    assign s2_write      = s2_valid_reg && s2_inrange_reg;
    assign s2_valid_next = s1_valid_reg;
    assign lw_valid_next = s2_write;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s2_write;
            mem_waddr = s2_addr_reg;
            mem_wdata = {result, s2_hist_reg};
        end
    end

    assign oq_push.valid         = s2_valid_reg;
    assign oq_push.data.cell_out = s2_cell_reg;
    assign oq_push.data.filtered = s2_inrange_reg ? result : '0;

    // ------------------------------------------------------------------
    // Control and payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg     <= slot_next;
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_inrange_reg <= in_range;
            s1_cell_reg    <= in_cell;
            s1_addr_reg    <= in_addr;
            s1_sample_reg  <= in_sample;
            s1_slot_reg    <= slot_next;
        end
        if (s1_valid_reg)
        begin
            s2_inrange_reg <= s1_inrange_reg;
            s2_cell_reg    <= s1_cell_reg;
            s2_addr_reg    <= s1_addr_reg;
            s2_hist_reg    <= new_hist;
            s2_tsum_reg    <= trim_sum;
            s2_prev_reg    <= s1_prev;
        end
        if (s2_write)
        begin
            lw_addr_reg   <= s2_addr_reg;
            lw_hist_reg   <= s2_hist_reg;
            lw_result_reg <= result;
        end
    end

    // ------------------------------------------------------------------
    // Result queue and output stream.
    // ------------------------------------------------------------------
    tmds_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (oq_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (oq_head),
        .count     (oq_count)
    );

    assign m_axis_tdata = OUT_TDATA_W'({oq_head.cell_out, oq_head.filtered});

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `TMDS_ASSERT_SAME(a_pipe_empty_while_clearing, clr_busy_reg,
        !s1_valid_reg && !s2_valid_reg, "item in pipeline during memory clear")
    `TMDS_ASSERT_SAME(a_queue_never_overbooked, 1'b1,
        occupancy <= (OQ_AW+2)'(OQ_DEPTH), "result queue overbooked")
    `TMDS_ASSERT_NEXT(a_clear_pass_ends, clr_busy_reg && clr_last,
        !clr_busy_reg, "memory clear did not finish")
    `TMDS_ASSERT_NEXT(a_last_write_tracked, s2_write,
        lw_valid_reg && (lw_addr_reg == $past(s2_addr_reg)), "write-back not tracked")

endmodule

`default_nettype wire
